[rtl/per_host_traffic_byte_counter_top_macros.svh]
// Assertion macros for the per-host byte counter.
// Included by the top level; no other dependencies.
`ifndef PER_HOST_TRAFFIC_BYTE_COUNTER_TOP_MACROS_SVH
`define PER_HOST_TRAFFIC_BYTE_COUNTER_TOP_MACROS_SVH

`ifndef SYNTH
`define PHTBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PHTBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PHTBC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PHTBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/phtbc_pkg.sv]
// Types and codes shared by the per-host byte counter.
// No dependencies.
`timescale 1ns / 1ps

package phtbc_pkg;

    typedef struct packed {
        logic [31:0] host;
        logic [63:0] upload;
        logic [63:0] download;
        logic [15:0] last;
    } t_entry;

    typedef enum logic [1:0] {
        KIND_PACKET = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_FORGET = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_NOMATCH  = 3'd4,
        ST_NEGATIVE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MISS,
        S_SH_RD,
        S_SH_WR,
        S_EMIT
    } t_state;

endpackage

[rtl/phtbc_ram.sv]
// Host table storage: one write port and one registered read port.
// Depends on phtbc_pkg for the entry type.
`timescale 1ns / 1ps

module phtbc_ram import phtbc_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/per_host_traffic_byte_counter_top.sv]
// Per-host IPv4 byte counter: a table scanned one slot at a time through one read port,
// each slot read (S_RD) and then compared (S_CMP). A hit ends the scan; a miss scans every
// host and then passes S_MISS; an add to a full table skips the scan and goes to S_EMIT.
// A forget that hits moves later entries down, each one read (S_SH_RD) and written (S_SH_WR).
// One item is in work at a time; a finished result waits in an output register.
// Reset is synchronous, active low, and empties the table and clears the local address.
`timescale 1ns / 1ps
`include "per_host_traffic_byte_counter_top_macros.svh"

module per_host_traffic_byte_counter_top import phtbc_pkg::*; #(
    parameter int MAX_HOSTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic [3:0]  i_ip_header_words,
    input  logic [3:0]  i_tcp_header_words,
    input  logic [15:0] i_ip_total_length,
    input  logic [31:0] i_host_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_entry_index,
    output logic [63:0] o_upload_bytes,
    output logic [63:0] o_download_bytes,
    output logic [15:0] o_last_payload
);

    localparam int CW = $clog2(MAX_HOSTS + 1);
    localparam int IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_host_count;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_local_addr;
    t_kind         r_kind;
    logic [31:0]   r_src;
    logic [31:0]   r_dst;
    logic [31:0]   r_host;
    logic [15:0]   r_payload;
    logic          r_neg;
    logic          r_dl;
    logic          r_ul;
    t_status       r_res_status;
    logic [3:0]    r_res_index;
    logic [63:0]   r_res_up;
    logic [63:0]   r_res_down;
    logic [15:0]   r_res_last;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [3:0]    r_out_index;
    logic [63:0]   r_out_up;
    logic [63:0]   r_out_down;
    logic [15:0]   r_out_last;

    logic          in_accept;
    logic          emit_load;
    logic          is_full;
    logic [CW-1:0] idx_next;
    logic          more;
    logic [6:0]    hdr_bytes;
    logic          in_neg;
    t_entry        rd_entry;
    t_entry        upd_entry;
    t_entry        new_entry;
    logic          hit_host;
    logic          hit_down;
    logic          hit_up;
    logic          hit;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [CW+3:0] idx_ext;
    logic [CW+3:0] cnt_ext;

    assign in_accept = i_in_valid && !o_in_stall;
    assign emit_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign is_full   = (r_host_count == CW'(MAX_HOSTS));
    assign idx_next  = r_idx + CW'(1);
    assign more      = (idx_next < r_host_count);
    assign hdr_bytes = {({1'b0, i_ip_header_words} + {1'b0, i_tcp_header_words}), 2'b00};
    assign in_neg    = (i_ip_total_length < {9'd0, hdr_bytes});
    assign idx_ext   = {4'd0, r_idx};
    assign cnt_ext   = {4'd0, r_host_count};

    assign hit_host = (rd_entry.host == r_host);
    assign hit_down = (rd_entry.host == r_src) && r_dl;
    assign hit_up   = (rd_entry.host == r_dst) && r_ul;
    assign hit      = (r_kind == KIND_PACKET) ? (hit_down || hit_up) : hit_host;

    always_comb begin
        upd_entry      = rd_entry;
        upd_entry.last = r_payload;
        if (hit_down) begin
            upd_entry.download = rd_entry.download + {48'd0, r_payload};
        end else begin
            upd_entry.upload = rd_entry.upload + {48'd0, r_payload};
        end
        new_entry.host     = r_host;
        new_entry.upload   = '0;
        new_entry.download = '0;
        new_entry.last     = '0;
    end

    phtbc_ram #(
        .DEPTH (MAX_HOSTS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rd_entry)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (t_kind'(i_kind) == KIND_ADD && is_full) begin
                        n_state = S_EMIT;
                    end else if (r_host_count == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:    n_state = S_CMP;
            S_CMP: begin
                if (hit) begin
                    n_state = (r_kind == KIND_FORGET && more) ? S_SH_RD : S_EMIT;
                end else begin
                    n_state = more ? S_RD : S_MISS;
                end
            end
            S_MISS:  n_state = S_EMIT;
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: n_state = more ? S_SH_RD : S_EMIT;
            S_EMIT: begin
                if (emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        ram_we     = 1'b0;
        ram_waddr  = r_idx[IW-1:0];
        ram_wdata  = upd_entry;
        unique case (r_state)
            S_CMP: begin
                ram_we = hit && (r_kind == KIND_PACKET);
            end
            S_MISS: begin
                ram_we    = (r_kind == KIND_ADD);
                ram_waddr = r_host_count[IW-1:0];
                ram_wdata = new_entry;
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[IW-1:0] - IW'(1);
                ram_wdata = rd_entry;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_host_count <= '0;
            r_local_addr <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_local_addr <= i_cfg_wr_data;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                end
                S_CMP: begin
                    if (more && (!hit || r_kind == KIND_FORGET)) begin
                        r_idx <= idx_next;
                    end
                    if (hit && r_kind == KIND_FORGET && !more) begin
                        r_host_count <= r_host_count - CW'(1);
                    end
                end
                S_MISS: begin
                    if (r_kind == KIND_ADD) begin
                        r_host_count <= r_host_count + CW'(1);
                    end
                end
                S_SH_WR: begin
                    if (more) begin
                        r_idx <= idx_next;
                    end else begin
                        r_host_count <= r_host_count - CW'(1);
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind       <= t_kind'(i_kind);
            r_src        <= i_source_address;
            r_dst        <= i_destination_address;
            r_host       <= i_host_address;
            r_neg        <= in_neg;
            r_payload    <= in_neg ? 16'd0 : (i_ip_total_length - {9'd0, hdr_bytes});
            r_dl         <= (r_local_addr == i_destination_address);
            r_ul         <= (r_local_addr == i_source_address);
            r_res_status <= ST_FULL;
            r_res_index  <= '0;
            r_res_up     <= '0;
            r_res_down   <= '0;
            r_res_last   <= '0;
        end
        if (r_state == S_CMP && hit) begin
            r_res_index <= idx_ext[3:0];
            if (r_kind == KIND_PACKET) begin
                r_res_status <= r_neg ? ST_NEGATIVE : ST_OK;
                r_res_up     <= upd_entry.upload;
                r_res_down   <= upd_entry.download;
                r_res_last   <= upd_entry.last;
            end else begin
                r_res_status <= (r_kind == KIND_ADD) ? ST_DUP : ST_OK;
                r_res_up     <= rd_entry.upload;
                r_res_down   <= rd_entry.download;
                r_res_last   <= rd_entry.last;
            end
        end
        if (r_state == S_MISS) begin
            r_res_up   <= '0;
            r_res_down <= '0;
            r_res_last <= '0;
            unique case (r_kind)
                KIND_ADD: begin
                    r_res_status <= ST_OK;
                    r_res_index  <= cnt_ext[3:0];
                end
                KIND_PACKET: begin
                    r_res_status <= ST_NOMATCH;
                    r_res_index  <= '0;
                end
                default: begin
                    r_res_status <= ST_UNKNOWN;
                    r_res_index  <= '0;
                end
            endcase
        end
        if (emit_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_up     <= r_res_up;
            r_out_down   <= r_res_down;
            r_out_last   <= r_res_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_index    = r_out_index;
    assign o_upload_bytes   = r_out_up;
    assign o_download_bytes = r_out_down;
    assign o_last_payload   = r_out_last;

    `PHTBC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_host_count <= CW'(MAX_HOSTS))
    `PHTBC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, r_state != S_IDLE)
    `PHTBC_ASSERT_IMPL(a_full_only_when_full, i_clk, i_rst_n,
        (r_state == S_EMIT) && (r_res_status == ST_FULL), is_full)

endmodule
